[src/lrubc_pkg.sv]
// Types and codes shared by the buffer cache cells and top level.
`default_nettype none
package lrubc_pkg;

	typedef enum logic [1:0] {
		MODE_GET     = 2'd0,
		MODE_WRITE   = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_IO_DONE = 2'd3
	} mode_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_UNREF  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [4:0]  slot;
	} req_t;

	typedef struct packed {
		logic [4:0] slot_out;
		logic       hit;
		logic       need_read;
		logic       need_write;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
		logic        valid;
		logic        dirty;
	} slot_data_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_HIT,
		OP_ALLOC,
		OP_WRITE,
		OP_REL,
		OP_DONE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [4:0]  slot;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HIT_SCAN,
		S_FREE_SCAN,
		S_EXEC,
		S_MOVE
	} state_t;

endpackage
`default_nettype wire

[src/lru_block_buffer_cache.sv]
// Top level of the LRU block buffer cache: scan control over a row of cells.
//
// Requests arrive as one beat on req, taken when start is high and busy low.
// Every request yields exactly one response beat on rsp, marked by done for
// one cycle; the receiver must take it then.
// The cells hold the slots in recency order, position 0 being the head.
// A get passes a token down the row, one position per cycle: first a tag
// match pass, then, on a miss, a pass for an unreferenced clean slot.
// A get on a hit ends at the hit position; on a miss it runs the whole match
// pass and then the free pass up to the first free slot or the row's end.
// Write and io_done pass through S_EXEC only. A release that drops a slot's
// count to zero then bubbles that slot up to the head; its response
// comes out before that move finishes, and busy holds until it is done.
// A new request can be taken in the cycle its predecessor's response is out, unless a release move is still under way.
// After reset all tags are zero and the head holds slot SLOT_COUNT-1,
// followed by SLOT_COUNT-2 down to 0; no clearing pass is needed.
`default_nettype none
module lru_block_buffer_cache import lrubc_pkg::*; #(
	parameter int SLOT_COUNT = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = (SW > 5) ? SW : 5;

	state_t state_q, state_d;
	req_t   req_q;
	logic [SLOT_COUNT-1:0] tok_q, tok_d, mv_q, mv_d;
	rsp_t   rsp_d;
	logic   done_d;
	cell_ctl_t ctl;

	slot_data_t      data_w [SLOT_COUNT];
	logic [SW-1:0]   id_w   [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] match_w, free_w, sel_w;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		slot_data_t    pd, nd;
		logic [SW-1:0] pi, ni;
		logic          tp, tn;
		if (i == 0) begin : g_first
			assign pd = '0;
			assign pi = '0;
			assign tp = 1'b0;
		end else begin : g_mid
			assign pd = data_w[i-1];
			assign pi = id_w[i-1];
			assign tp = mv_q[i];
		end
		if (i == SLOT_COUNT - 1) begin : g_last
			assign nd = '0;
			assign ni = '0;
			assign tn = 1'b0;
		end else begin : g_inner
			assign nd = data_w[i+1];
			assign ni = id_w[i+1];
			assign tn = mv_q[i+1];
		end
		lrubc_cell #(.SW(SW), .RESET_ID(SW'(SLOT_COUNT - 1 - i))) u_cell (
			.clk, .arst_n, .ctl, .tok(tok_q[i]),
			.take_prev(tp), .take_next(tn),
			.prev_data(pd), .prev_id(pi), .next_data(nd), .next_id(ni),
			.data_q(data_w[i]), .id_q(id_w[i]),
			.tag_match(match_w[i]), .is_free(free_w[i]), .sel(sel_w[i])
		);
	end

	// Pick the data of the token cell and of the addressed cell.
	slot_data_t tok_data, sel_data;
	logic [SW-1:0] tok_id;
	always_comb begin
		tok_data = '0;
		sel_data = '0;
		tok_id   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			tok_data = tok_data | (tok_q[i] ? data_w[i] : '0);
			tok_id   = tok_id   | (tok_q[i] ? id_w[i] : '0);
			sel_data = sel_data | (sel_w[i] ? data_w[i] : '0);
		end
	end

	logic hit_now, free_now, last_pos, slot_ok;
	assign hit_now  = |(tok_q & match_w);
	assign free_now = |(tok_q & free_w);
	assign last_pos = tok_q[SLOT_COUNT-1];
	assign slot_ok  = ((CW+1)'(req_q.slot) < (CW+1)'(SLOT_COUNT));
	assign busy     = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (start) state_d = (mode_t'(req.mode) == MODE_GET) ? S_HIT_SCAN : S_EXEC;
			S_HIT_SCAN:
				if (hit_now) state_d = S_IDLE;
				else if (last_pos) state_d = S_FREE_SCAN;
			S_FREE_SCAN:
				if (free_now || last_pos) state_d = S_IDLE;
			S_EXEC:
				if (slot_ok && mode_t'(req_q.mode) == MODE_RELEASE &&
				    sel_data.cnt == 8'd1 && !sel_w[0])
					state_d = S_MOVE;
				else
					state_d = S_IDLE;
			S_MOVE:
				if (mv_q[1]) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '{op: OP_NONE, dev: req_q.device, blk: req_q.block_number,
		             slot: req_q.slot};
		tok_d    = tok_q;
		mv_d     = mv_q;
		rsp_d    = '0;
		done_d   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				tok_d    = '0;
				tok_d[0] = 1'b1;
				mv_d     = '0;
			end
			S_HIT_SCAN: begin
				if (hit_now) begin
					ctl.op          = OP_HIT;
					done_d          = 1'b1;
					rsp_d.slot_out  = 5'(tok_id);
					rsp_d.hit       = 1'b1;
					rsp_d.need_read = !tok_data.valid;
				end else if (last_pos) begin
					tok_d    = '0;
					tok_d[0] = 1'b1;
				end else begin
					tok_d = tok_q << 1;
				end
			end
			S_FREE_SCAN: begin
				tok_d = tok_q << 1;
				if (free_now) begin
					ctl.op          = OP_ALLOC;
					done_d          = 1'b1;
					rsp_d.slot_out  = 5'(tok_id);
					rsp_d.need_read = 1'b1;
				end else if (last_pos) begin
					done_d       = 1'b1;
					rsp_d.status = ST_NOFREE;
				end
			end
			S_EXEC: begin
				done_d         = 1'b1;
				rsp_d.slot_out = req_q.slot;
				if (slot_ok) begin
					unique case (mode_t'(req_q.mode))
						MODE_WRITE: begin
							ctl.op           = OP_WRITE;
							rsp_d.need_write = 1'b1;
						end
						MODE_RELEASE:
							if (sel_data.cnt == 8'd0) begin
								rsp_d.status = ST_UNREF;
							end else begin
								ctl.op = OP_REL;
								if (sel_data.cnt == 8'd1) mv_d = sel_w;
							end
						MODE_IO_DONE: ctl.op = OP_DONE;
						default: ;
					endcase
				end
			end
			S_MOVE: mv_d = mv_q >> 1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tok_q   <= '0;
			mv_q    <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			tok_q   <= tok_d;
			mv_q    <= mv_d;
			done    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) req_q <= req;
		rsp <= rsp_d;
	end

	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HIT_SCAN || state_q == S_FREE_SCAN) |-> $onehot(tok_q))
		else $error("scan token lost or duplicated");
	a_mv_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> ($onehot(mv_q) && !mv_q[0]))
		else $error("move marker invalid");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response without a request in flight");
endmodule
`default_nettype wire

[src/lrubc_cell.sv]
// One recency-list position: holds a slot id and that slot's tags and marks.
`default_nettype none
module lrubc_cell import lrubc_pkg::*; #(
	parameter int SW = 5,
	parameter logic [SW-1:0] RESET_ID = '0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctl_t  ctl,
	input  wire logic       tok,
	input  wire logic       take_prev,
	input  wire logic       take_next,
	input  wire slot_data_t prev_data,
	input  wire logic [SW-1:0] prev_id,
	input  wire slot_data_t next_data,
	input  wire logic [SW-1:0] next_id,
	output slot_data_t      data_q,
	output logic [SW-1:0]   id_q,
	output logic            tag_match,
	output logic            is_free,
	output logic            sel
);
	localparam int CW = (SW > 5) ? SW : 5;

	assign tag_match = (data_q.dev == ctl.dev) && (data_q.blk == ctl.blk);
	assign is_free   = (data_q.cnt == 8'd0) && !data_q.dirty;
	assign sel       = (CW'(id_q) == CW'(ctl.slot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
			id_q   <= RESET_ID;
		end else if (take_prev) begin
			data_q <= prev_data;
			id_q   <= prev_id;
		end else if (take_next) begin
			data_q <= next_data;
			id_q   <= next_id;
		end else begin
			unique case (ctl.op)
				OP_HIT: if (tok && data_q.cnt != 8'hFF) data_q.cnt <= data_q.cnt + 8'd1;
				OP_ALLOC: if (tok) begin
					data_q.dev   <= ctl.dev;
					data_q.blk   <= ctl.blk;
					data_q.cnt   <= 8'd1;
					data_q.valid <= 1'b0;
					data_q.dirty <= 1'b0;
				end
				OP_WRITE: if (sel) data_q.dirty <= 1'b1;
				OP_REL:   if (sel) data_q.cnt <= data_q.cnt - 8'd1;
				OP_DONE: if (sel) begin
					data_q.dirty <= 1'b0;
					data_q.valid <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
